// ===== sv/baca_pkg.sv =====
`default_nettype none

package baca_pkg;

    // field widths
    localparam int RAW_W    = 24;
    localparam int COEF_W   = 16;
    localparam int TEMP_W   = 19;
    localparam int PRESS_W  = 18;
    localparam int HEIGHT_W = 24;

    // internal widths
    localparam int DT_W   = 25;  // d2 - c5*2^8
    localparam int PROD_W = 42;  // dt times a coefficient
    localparam int ACC_W  = 40;  // offset and sensitivity
    localparam int CORR_W = 39;  // cold corrections
    localparam int SQ_W   = 35;  // squared temperature distances
    localparam int NINE_W = 21;  // 9 * |d|
    localparam int MAG_W  = 23;  // |height|

    // apb register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_C1 = 3'd0;
    localparam logic [2:0] REG_C2 = 3'd1;
    localparam logic [2:0] REG_C3 = 3'd2;
    localparam logic [2:0] REG_C4 = 3'd3;
    localparam logic [2:0] REG_C5 = 3'd4;
    localparam logic [2:0] REG_C6 = 3'd5;

    // compensation constants
    localparam logic signed [TEMP_W-1:0] TEMP_BASE  = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] COLD_SHIFT = 19'sd3500;   // (temp + 1500) - (temp - 2000)
    localparam logic [PRESS_W-1:0]       PRESS_MAX  = 18'd262143;
    localparam logic [PRESS_W-1:0]       PRESS_SEA  = 18'd101000;

    // floor(x / 5^11) for x < 2^48 via reciprocal 2^48 / 5^11 and one correction
    localparam logic [22:0] RECIP = 23'd5764607;
    localparam logic [25:0] DIV5  = 26'd48828125;

    typedef struct packed {
        logic [COEF_W-1:0] sens_base_c1;
        logic [COEF_W-1:0] offset_base_c2;
        logic [COEF_W-1:0] sens_tempco_c3;
        logic [COEF_W-1:0] offset_tempco_c4;
        logic [COEF_W-1:0] ref_temp_c5;
        logic [COEF_W-1:0] temp_slope_c6;
    } baca_coef_t;

endpackage

`default_nettype wire

// ===== sv/baca_front.sv =====
`default_nettype none

module baca_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  baca_pkg::baca_coef_t                coef,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [baca_pkg::RAW_W-1:0]          in_d1,
    input  logic [baca_pkg::RAW_W-1:0]          in_d2,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [baca_pkg::RAW_W-1:0]          out_d1,
    output logic signed [baca_pkg::ACC_W-1:0]   out_off,
    output logic signed [baca_pkg::ACC_W-1:0]   out_sens,
    output logic signed [baca_pkg::TEMP_W-1:0]  out_temp
);
    import baca_pkg::*;

    localparam int STAGES = 6;

    logic [STAGES-1:0] vld_reg, vld_next, en;

    logic [RAW_W-1:0] d1_reg [STAGES];

    logic signed [DT_W-1:0]   f1_dt_reg;
    logic signed [PROD_W-1:0] f2_p3_reg, f2_p4_reg, f2_p6_reg;
    logic signed [ACC_W-1:0]  f3_off_reg, f3_sens_reg, f4_off_reg, f4_sens_reg;
    logic signed [ACC_W-1:0]  f5_off_reg, f5_sens_reg, f6_off_reg, f6_sens_reg;
    logic signed [TEMP_W-1:0] f3_q_reg, f3_v_reg, f3_temp_reg;
    logic signed [TEMP_W-1:0] f4_temp_reg, f5_temp_reg, f6_temp_reg;
    logic [SQ_W-1:0]          f4_t_reg, f4_u_reg;
    logic                     f4_cold_t_reg, f4_cold_u_reg;
    logic [CORR_W-1:0]        f5_off2_reg, f5_sens2_reg;

    logic signed [TEMP_W-1:0]   q_now;
    logic signed [2*TEMP_W-1:0] tsq, usq;
    logic [SQ_W+2:0]            t5, u7, u11;
    logic [CORR_W-1:0]          off2, sens2;

    // stall chain: a stage loads when it is empty or its successor loads
    always_comb begin
        en[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb begin
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[STAGES-1];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            d1_reg[0] <= in_d1;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (en[k]) begin
                d1_reg[k] <= d1_reg[k-1];
            end
        end
    end

    // cold correction terms
    assign q_now = f2_p6_reg[PROD_W-1:23];
    assign tsq   = f3_q_reg * f3_q_reg;
    assign usq   = f3_v_reg * f3_v_reg;

    always_comb begin
        t5  = {3'b000, f4_t_reg} + {1'b0, f4_t_reg, 2'b00};
        u7  = {f4_u_reg, 3'b000} - {3'b000, f4_u_reg};
        u11 = {f4_u_reg, 3'b000} + {2'b00, f4_u_reg, 1'b0} + {3'b000, f4_u_reg};
        off2  = {CORR_W{1'b0}};
        sens2 = {CORR_W{1'b0}};
        if (f4_cold_t_reg) begin
            off2  = {2'b00, t5[SQ_W+2:1]};
            sens2 = {3'b000, t5[SQ_W+2:2]};
            if (f4_cold_u_reg) begin
                off2  = {2'b00, t5[SQ_W+2:1]} + {1'b0, u7};
                sens2 = {3'b000, t5[SQ_W+2:2]} + {2'b00, u11[SQ_W+2:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            f1_dt_reg <= {1'b0, in_d2} - {1'b0, coef.ref_temp_c5, 8'h00};
        end
        if (en[1]) begin
            f2_p3_reg <= f1_dt_reg * $signed({1'b0, coef.sens_tempco_c3});
            f2_p4_reg <= f1_dt_reg * $signed({1'b0, coef.offset_tempco_c4});
            f2_p6_reg <= f1_dt_reg * $signed({1'b0, coef.temp_slope_c6});
        end
        if (en[2]) begin
            f3_off_reg  <= {8'h00, coef.offset_base_c2, 16'h0000}
                         + {{5{f2_p4_reg[PROD_W-1]}}, f2_p4_reg[PROD_W-1:7]};
            f3_sens_reg <= {9'h000, coef.sens_base_c1, 15'h0000}
                         + {{6{f2_p3_reg[PROD_W-1]}}, f2_p3_reg[PROD_W-1:8]};
            f3_q_reg    <= q_now;
            f3_v_reg    <= q_now + COLD_SHIFT;
            f3_temp_reg <= q_now + TEMP_BASE;
        end
        if (en[3]) begin
            f4_t_reg      <= tsq[SQ_W-1:0];
            f4_u_reg      <= usq[SQ_W-1:0];
            f4_cold_t_reg <= f3_q_reg[TEMP_W-1];
            f4_cold_u_reg <= f3_v_reg[TEMP_W-1];
            f4_off_reg    <= f3_off_reg;
            f4_sens_reg   <= f3_sens_reg;
            f4_temp_reg   <= f3_temp_reg;
        end
        if (en[4]) begin
            f5_off2_reg  <= off2;
            f5_sens2_reg <= sens2;
            f5_off_reg   <= f4_off_reg;
            f5_sens_reg  <= f4_sens_reg;
            f5_temp_reg  <= f4_temp_reg;
        end
        if (en[5]) begin
            f6_off_reg  <= f5_off_reg - $signed({1'b0, f5_off2_reg});
            f6_sens_reg <= f5_sens_reg - $signed({1'b0, f5_sens2_reg});
            f6_temp_reg <= f5_temp_reg;
        end
    end

    assign out_d1   = d1_reg[STAGES-1];
    assign out_off  = f6_off_reg;
    assign out_sens = f6_sens_reg;
    assign out_temp = f6_temp_reg;

endmodule

`default_nettype wire

// ===== sv/baca_press.sv =====
`default_nettype none

module baca_press (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [baca_pkg::RAW_W-1:0]          in_d1,
    input  logic signed [baca_pkg::ACC_W-1:0]   in_off,
    input  logic signed [baca_pkg::ACC_W-1:0]   in_sens,
    input  logic signed [baca_pkg::TEMP_W-1:0]  in_temp,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [baca_pkg::PRESS_W-1:0]        out_press,
    output logic signed [baca_pkg::TEMP_W-1:0]  out_temp
);
    import baca_pkg::*;

    localparam int STAGES = 4;

    logic [STAGES-1:0] vld_reg, vld_next, en;

    logic signed [TEMP_W-1:0] temp_reg [STAGES];

    logic [43:0]             p1_lo_reg;
    logic signed [44:0]      p1_hi_reg;
    logic signed [ACC_W-1:0] p1_off_reg, p2_off_reg;
    logic [63:0]             p2_prod_reg;
    logic [43:0]             p3_diff_reg;
    logic [PRESS_W-1:0]      p4_press_reg;

    logic [PRESS_W-1:0] press_sat;

    always_comb begin
        en[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb begin
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[STAGES-1];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            temp_reg[0] <= in_temp;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (en[k]) begin
                temp_reg[k] <= temp_reg[k-1];
            end
        end
    end

    // floor of the 29-bit pressure, clamped to the output range
    always_comb begin
        if (p3_diff_reg[43]) begin
            press_sat = '0;
        end else if (|p3_diff_reg[42:33]) begin
            press_sat = PRESS_MAX;
        end else begin
            press_sat = p3_diff_reg[32:15];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            p1_lo_reg  <= in_d1 * in_sens[19:0];
            p1_hi_reg  <= $signed({1'b0, in_d1}) * $signed(in_sens[ACC_W-1:20]);
            p1_off_reg <= in_off;
        end
        if (en[1]) begin
            p2_prod_reg <= {p1_hi_reg[43:0], 20'h00000} + {20'h00000, p1_lo_reg};
            p2_off_reg  <= p1_off_reg;
        end
        if (en[2]) begin
            p3_diff_reg <= {p2_prod_reg[63], p2_prod_reg[63:21]}
                         - {{4{p2_off_reg[ACC_W-1]}}, p2_off_reg};
        end
        if (en[3]) begin
            p4_press_reg <= press_sat;
        end
    end

    assign out_press = p4_press_reg;
    assign out_temp  = temp_reg[STAGES-1];

endmodule

`default_nettype wire

// ===== sv/baca_height.sv =====
`default_nettype none

module baca_height (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [baca_pkg::PRESS_W-1:0]         in_press,
    input  logic signed [baca_pkg::TEMP_W-1:0]   in_temp,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [baca_pkg::PRESS_W-1:0]         out_press,
    output logic signed [baca_pkg::TEMP_W-1:0]   out_temp,
    output logic signed [baca_pkg::HEIGHT_W-1:0] out_height
);
    import baca_pkg::*;

    localparam int STAGES = 9;
    localparam int XLO_W  = 27;

    logic [STAGES-1:0] vld_reg, vld_next, en;

    logic [PRESS_W-1:0]       press_reg [STAGES];
    logic signed [TEMP_W-1:0] temp_reg  [STAGES];
    logic                     neg_reg   [STAGES];
    logic [NINE_W-1:0]        nine_reg  [STAGES];

    logic [PRESS_W-1:0]   h1_m_reg, h2_m_reg;
    logic [2*PRESS_W-1:0] h2_sq_reg;
    logic [3*PRESS_W-1:0] h3_cube_reg;
    logic [47:0]          h4_x_reg;
    logic [46:0]          h5_plo_reg, h5_phi_reg;
    logic [XLO_W-1:0]     h5_xlo_reg, h6_xlo_reg, h7_xlo_reg, h7_qd_reg;
    logic [21:0]          h6_q0_reg, h7_q0_reg;
    logic [MAG_W-1:0]     h8_mag_reg;
    logic [HEIGHT_W-1:0]  h9_height_reg;

    logic [PRESS_W:0]     d_diff, d_abs;
    logic [NINE_W-1:0]    nine_m;
    logic [3*PRESS_W+5:0] n82;
    logic [70:0]          recip_sum;
    logic [47:0]          qd;
    logic [XLO_W-1:0]     rem;
    logic                 corr;

    always_comb begin
        en[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb begin
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[STAGES-1];

    // d = sea level - p, split into sign and magnitude
    always_comb begin
        d_diff = {1'b0, PRESS_SEA} - {1'b0, in_press};
        d_abs  = d_diff[PRESS_W] ? (~d_diff + 1'b1) : d_diff;
        nine_m = {d_abs[PRESS_W-1:0], 3'b000} + {3'b000, d_abs[PRESS_W-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            press_reg[0] <= in_press;
            temp_reg[0]  <= in_temp;
            neg_reg[0]   <= d_diff[PRESS_W];
            nine_reg[0]  <= nine_m;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (en[k]) begin
                press_reg[k] <= press_reg[k-1];
                temp_reg[k]  <= temp_reg[k-1];
                neg_reg[k]   <= neg_reg[k-1];
                nine_reg[k]  <= nine_reg[k-1];
            end
        end
    end

    // 82 * |d|^3, then floor by 2^11 ahead of the divide by 5^11
    assign n82 = {h3_cube_reg, 6'b000000} + {2'b00, h3_cube_reg, 4'b0000}
               + {5'b00000, h3_cube_reg, 1'b0};
    assign recip_sum = {h5_phi_reg, 24'h000000} + {24'h000000, h5_plo_reg};
    assign qd        = h6_q0_reg * DIV5;
    assign rem       = h7_xlo_reg - h7_qd_reg;
    assign corr      = (rem >= {1'b0, DIV5});

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            h1_m_reg <= d_abs[PRESS_W-1:0];
        end
        if (en[1]) begin
            h2_sq_reg <= h1_m_reg * h1_m_reg;
            h2_m_reg  <= h1_m_reg;
        end
        if (en[2]) begin
            h3_cube_reg <= h2_sq_reg * h2_m_reg;
        end
        if (en[3]) begin
            h4_x_reg <= n82[58:11];
        end
        if (en[4]) begin
            h5_plo_reg <= h4_x_reg[23:0] * RECIP;
            h5_phi_reg <= h4_x_reg[47:24] * RECIP;
            h5_xlo_reg <= h4_x_reg[XLO_W-1:0];
        end
        if (en[5]) begin
            h6_q0_reg  <= recip_sum[69:48];
            h6_xlo_reg <= h5_xlo_reg;
        end
        if (en[6]) begin
            h7_qd_reg  <= qd[XLO_W-1:0];
            h7_q0_reg  <= h6_q0_reg;
            h7_xlo_reg <= h6_xlo_reg;
        end
        if (en[7]) begin
            // quotient estimate is low by at most one
            h8_mag_reg <= {2'b00, nine_reg[6]} + {1'b0, h7_q0_reg}
                        + {{(MAG_W-1){1'b0}}, corr};
        end
        if (en[8]) begin
            h9_height_reg <= neg_reg[7] ? ({HEIGHT_W{1'b0}} - {1'b0, h8_mag_reg})
                                        : {1'b0, h8_mag_reg};
        end
    end

    assign out_press  = press_reg[STAGES-1];
    assign out_temp   = temp_reg[STAGES-1];
    assign out_height = h9_height_reg;

endmodule

`default_nettype wire

// ===== sv/baro_compensate_altitude_top.sv =====
`default_nettype none

// barometer compensation with altitude estimate
//
// input channel (s_*): one word carries a raw pressure conversion and a raw
// temperature conversion, taken when s_valid and s_ready are both high
// result channel (m_*): one word per input word, in order, with temperature
// in centidegrees, pressure in pascal (clamped to 0..262143) and height in cm
// apb port: six 16-bit calibration coefficients at byte offsets 0x00..0x14,
// write only while no word is in flight; pready is tied high
//
// the pipeline runs from input handshake to m_valid through six stages of
// calibration, four of pressure multiply and clamp and nine of cube and divide
// throughput is one word per cycle while m_ready is high; every stage has its own valid bit
// a stalled receiver holds the last stage, upstream stages keep filling
// bubbles, and s_ready drops only once every stage holds a word
// reset clears all valid bits and sets every coefficient to zero
module baro_compensate_altitude_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input words
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [baca_pkg::RAW_W-1:0]           s_pressure_raw,
    input  logic [baca_pkg::RAW_W-1:0]           s_temperature_raw,
    // result words
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [baca_pkg::TEMP_W-1:0]   m_temperature_centi,
    output logic [baca_pkg::PRESS_W-1:0]         m_pressure_pa,
    output logic signed [baca_pkg::HEIGHT_W-1:0] m_height_cm,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [baca_pkg::ADDR_W-1:0]          paddr,
    input  logic [baca_pkg::DATA_W-1:0]          pwdata,
    output logic [baca_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);
    import baca_pkg::*;

    baca_coef_t coef_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    // front to pressure stage
    logic                     fr_valid, fr_ready;
    logic [RAW_W-1:0]         fr_d1;
    logic signed [ACC_W-1:0]  fr_off, fr_sens;
    logic signed [TEMP_W-1:0] fr_temp;

    // pressure to height stage
    logic                     pr_valid, pr_ready;
    logic [PRESS_W-1:0]       pr_press;
    logic signed [TEMP_W-1:0] pr_temp;

    // coefficient registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_C1: coef_reg.sens_base_c1     <= pwdata[COEF_W-1:0];
                REG_C2: coef_reg.offset_base_c2   <= pwdata[COEF_W-1:0];
                REG_C3: coef_reg.sens_tempco_c3   <= pwdata[COEF_W-1:0];
                REG_C4: coef_reg.offset_tempco_c4 <= pwdata[COEF_W-1:0];
                REG_C5: coef_reg.ref_temp_c5      <= pwdata[COEF_W-1:0];
                REG_C6: coef_reg.temp_slope_c6    <= pwdata[COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read mux, unmapped offsets read zero
    always_comb begin
        unique case (reg_idx)
            REG_C1:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef_reg.sens_base_c1};
            REG_C2:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef_reg.offset_base_c2};
            REG_C3:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef_reg.sens_tempco_c3};
            REG_C4:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef_reg.offset_tempco_c4};
            REG_C5:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef_reg.ref_temp_c5};
            REG_C6:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef_reg.temp_slope_c6};
            default: prdata = '0;
        endcase
    end

    // dt, offset, sensitivity, temperature and cold corrections
    baca_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coef      (coef_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_d1     (s_pressure_raw),
        .in_d2     (s_temperature_raw),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_d1    (fr_d1),
        .out_off   (fr_off),
        .out_sens  (fr_sens),
        .out_temp  (fr_temp)
    );

    // d1 * sens, offset removal, clamp
    baca_press u_press (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_d1     (fr_d1),
        .in_off    (fr_off),
        .in_sens   (fr_sens),
        .in_temp   (fr_temp),
        .out_valid (pr_valid),
        .out_ready (pr_ready),
        .out_press (pr_press),
        .out_temp  (pr_temp)
    );

    // cubic height polynomial with reciprocal divide
    baca_height u_height (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (pr_valid),
        .in_ready   (pr_ready),
        .in_press   (pr_press),
        .in_temp    (pr_temp),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_press  (m_pressure_pa),
        .out_temp   (m_temperature_centi),
        .out_height (m_height_cm)
    );

`ifndef NO_ASSERTIONS
    // above sea-level pressure the height is below zero
    a_height_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_pressure_pa > PRESS_SEA) |-> m_height_cm[HEIGHT_W-1])
        else $error("height not negative above sea-level pressure");

    // below sea-level pressure the height is above zero
    a_height_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_pressure_pa < PRESS_SEA)
        |-> !m_height_cm[HEIGHT_W-1] && (m_height_cm != '0))
        else $error("height not positive below sea-level pressure");

    // sea-level pressure gives zero height
    a_height_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_pressure_pa == PRESS_SEA) |-> (m_height_cm == '0))
        else $error("height not zero at sea-level pressure");

    // an empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output stage empty");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");
`endif

endmodule

`default_nettype wire
